// ----- hdl/f8c_pkg.sv -----
// shared constants and types for the fp32 to fp8 converter
package f8c_pkg;

  localparam logic [31:0] E4M3_MAX_BITS = 32'h43E0_0000;
  localparam logic [31:0] E5M2_MAX_BITS = 32'h4760_0000;
  localparam logic [6:0]  E4M3_MAX_CODE = 7'h7E;
  localparam logic [6:0]  E5M2_MAX_CODE = 7'h7B;
  localparam logic [6:0]  E4M3_NAN_CODE = 7'h7F;
  localparam logic [6:0]  E5M2_NAN_CODE = 7'h7E;
  localparam logic        FMT_E4M3 = 1'b0;
  localparam logic        FMT_E5M2 = 1'b1;
  localparam logic [0:0]  REG_FORMAT_SELECT = 1'b0;

  typedef struct packed {
    logic [7:0] fp8_code;
    logic       saturated;
  } f8c_result_t;

endpackage

// ----- hdl/f8c_encode.sv -----
// combinational fp32 to fp8 encoder with round to nearest, ties away
module f8c_encode (
  input  logic                 fmt,
  input  logic [31:0]          bits,
  output f8c_pkg::f8c_result_t res
);

  logic        sign;
  logic [30:0] mag;
  logic [7:0]  efield;
  logic [22:0] frac;
  logic [6:0]  maxcode;
  logic [6:0]  nancode;
  logic [31:0] maxbits;
  logic [23:0] sig;
  logic [8:0]  e_un;      // unbiased-like: effective exponent field (1 for subnormal)
  logic [8:0]  te_f;      // target exponent field in fp32 bias, clamped to min normal
  logic [8:0]  shift;
  logic [24:0] units;
  logic [8:0]  c;
  logic [8:0]  tebase;
  logic [8:0]  minfield;

  always_comb begin
    sign    = bits[31];
    mag     = bits[30:0];
    efield  = mag[30:23];
    frac    = mag[22:0];
    maxcode = (fmt == f8c_pkg::FMT_E5M2) ? f8c_pkg::E5M2_MAX_CODE : f8c_pkg::E4M3_MAX_CODE;
    nancode = (fmt == f8c_pkg::FMT_E5M2) ? f8c_pkg::E5M2_NAN_CODE : f8c_pkg::E4M3_NAN_CODE;
    maxbits = (fmt == f8c_pkg::FMT_E5M2) ? f8c_pkg::E5M2_MAX_BITS : f8c_pkg::E4M3_MAX_BITS;
    // smallest normal exponent field in fp32 bias: 127+1-bias
    minfield = (fmt == f8c_pkg::FMT_E5M2) ? 9'd113 : 9'd121;
    sig   = (efield != 8'd0) ? {1'b1, frac} : {1'b0, frac};
    e_un  = (efield != 8'd0) ? {1'b0, efield} : 9'd1;
    te_f  = (e_un < minfield) ? minfield : e_un;
    // shift = te - mbits - e + 23
    shift = te_f - e_un + ((fmt == f8c_pkg::FMT_E5M2) ? 9'd21 : 9'd20);
    if (shift >= 9'd26) begin
      units = '0;
    end else begin
      units = ({1'b0, sig} + (25'd1 << (shift - 9'd1))) >> shift;
    end
    // exponent field of fp8 before adding units: te + bias - 1
    tebase = te_f - minfield;
    c = ((fmt == f8c_pkg::FMT_E5M2) ? {tebase[6:0], 2'b00} : {tebase[5:0], 3'b000})
        + units[8:0];
    res.saturated = 1'b0;
    res.fp8_code  = {sign, 7'd0};
    if (efield == 8'hFF && frac != 23'd0) begin
      res.fp8_code = {sign, nancode};
    end else if (mag == 31'd0) begin
      res.fp8_code = 8'h00;
    end else if ({1'b0, mag} > maxbits) begin
      res.fp8_code  = {sign, maxcode};
      res.saturated = 1'b1;
    end else if (c > {2'b00, maxcode}) begin
      res.fp8_code  = {sign, maxcode};
      res.saturated = 1'b1;
    end else begin
      res.fp8_code = {sign, c[6:0]};
    end
  end

endmodule

// ----- hdl/fp32_to_fp8_converter.sv -----
// path: an input beat passes through the input register, the encoder and then the result register
// throughput: one beat per cycle while out_stall is low, set by the single-pass encoder between the two registers
// a held result does not block intake while the input register is empty
// reset: synchronous active-low rst_n clears valids and sets format_select to e4m3
module fp32_to_fp8_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_single_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_fp8_code,
  output logic        out_saturated,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                 fmt_r;
  logic                 a_valid_r;
  logic [31:0]          a_bits_r;
  logic                 b_valid_r;
  f8c_pkg::f8c_result_t b_res_r;
  f8c_pkg::f8c_result_t enc_res;
  logic                 b_load;
  logic                 a_free;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, fmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= f8c_pkg::FMT_E4M3;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[1:1] == f8c_pkg::REG_FORMAT_SELECT) begin
      fmt_r <= cfg_pwdata[0];
    end
  end

  f8c_encode u_enc (.fmt(fmt_r), .bits(a_bits_r), .res(enc_res));

  assign b_load   = a_valid_r && (!b_valid_r || !out_stall);
  assign a_free   = !a_valid_r || b_load;
  assign in_stall = !a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_free) a_valid_r <= in_valid;
      if (b_load) b_valid_r <= 1'b1;
      else if (!out_stall) b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) a_bits_r <= in_single_bits;
    if (b_load) b_res_r <= enc_res;
  end

  assign out_valid     = b_valid_r;
  assign out_fp8_code  = b_res_r.fp8_code;
  assign out_saturated = b_res_r.saturated;

endmodule

// ----- hdl/f8c_checker.sv -----
// port-level checks for the fp32 to fp8 converter
module f8c_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_fp8_code,
  input logic       out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fp8_code))
    else $error("stalled result beat changed");

  a_sat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_fp8_code[6:0] == f8c_pkg::E4M3_MAX_CODE
                                   || out_fp8_code[6:0] == f8c_pkg::E5M2_MAX_CODE)
    else $error("saturated beat without max code");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not arrive");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fp32_to_fp8_converter f8c_checker u_f8c_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_fp8_code(out_fp8_code), .out_saturated(out_saturated)
);
